[rtl/kwmh_pkg.sv]
// Shared types for the k-way merge heap: channel payloads and sequencer states.
// No dependencies; compiled first.
package kwmh_pkg;

  localparam int unsigned SRC_W  = 4;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned CFG_W  = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

  typedef struct packed {
    logic [SRC_W-1:0]        source_index;
    logic signed [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0]        row_tag;
    logic                    stream_ended;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0]        out_source;
    logic signed [KEY_W-1:0] out_key;
    logic [TAG_W-1:0]        out_tag;
    logic                    last;
  } out_item_t;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_UP_REQ   = 11'b000_0000_0010,
    ST_UP_CMP   = 11'b000_0000_0100,
    ST_POP_REQ  = 11'b000_0000_1000,
    ST_POP_ROOT = 11'b000_0001_0000,
    ST_POP_LAST = 11'b000_0010_0000,
    ST_DN_L     = 11'b000_0100_0000,
    ST_DN_LC    = 11'b000_1000_0000,
    ST_DN_RC    = 11'b001_0000_0000,
    ST_DN_DEC   = 11'b010_0000_0000,
    ST_EMIT     = 11'b100_0000_0000
  } state_e;

endpackage

[rtl/kwmh_stream_if.sv]
// Valid/ready channel carrying one payload per transaction.
// Payload type comes from kwmh_pkg at instantiation.
interface kwmh_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/kwmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwmh_ram #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/k_way_merge_heap.sv]
// k-way merge through a min-heap held in one RAM, driven by a small sequencer.
// Depends on kwmh_pkg, kwmh_stream_if and kwmh_ram.
// Usage:
//   in_i carries one source's next head (key, tag) or an end-of-stream mark.
//   Program sources_in_use through cfg_we_i/cfg_wdata_i while idle (reset 2).
//   Priming takes one transaction per source in use; the last of them pops the
//   smallest entry onto out_o. After that, send the refill for out_source of
//   the last result; each matching transaction pushes it (unless ended) and
//   pops the next smallest. Ties go to the lower source index. last marks an
//   empty heap after the pop. Mismatched refills and items after the merge
//   ends are dropped without a result.
// Timing:
//   in_i.ready is high only while the sequencer is idle. All work shares one RAM
//   read port and one key/source comparator, so a push climbs and a pop descends
//   the heap one level at a time (UP_REQ/UP_CMP; DN_L, DN_LC, DN_RC, DN_DEC),
//   and no new transaction is taken until both are done; out_o.valid rises in
//   the same cycle that in_i.ready returns high.
// Reset clears counts and flags; heap RAM contents need no clearing.
// A result waits in the output register while out_o.ready is low; the next
// input is still taken, and the sequencer holds only if a second result is due.
module k_way_merge_heap #(
  parameter int unsigned MAX_SOURCES = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kwmh_pkg::CFG_W-1:0]    cfg_wdata_i,
  kwmh_stream_if.sink                   in_i,
  kwmh_stream_if.source                 out_o
);

  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned AW = $clog2(MAX_SOURCES);
  localparam int unsigned CW = $clog2(MAX_SOURCES + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned SW = kwmh_pkg::SRC_W;
  localparam int unsigned TW = kwmh_pkg::TAG_W;
  localparam int unsigned WW = SW + KW + TW;
  localparam int unsigned PW = kwmh_pkg::CFG_W;

  kwmh_pkg::state_e state_q, state_d;

  logic [PW-1:0] cfg_q;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] primed_cnt_q, primed_cnt_d;
  logic [SW-1:0] awaited_q, awaited_d;
  logic          primed_q, primed_d;
  logic          pending_q, pending_d;
  logic          do_pop_q, do_pop_d;

  logic [WW-1:0] ent_q, ent_d;
  logic [WW-1:0] min_q, min_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] midx_q, midx_d;
  logic          msel_q, msel_d;

  logic [SW-1:0] res_src_q, res_src_d;
  logic [KW-1:0] res_key_q, res_key_d;
  logic [TW-1:0] res_tag_q, res_tag_d;
  logic          res_last_q, res_last_d;

  logic                 out_valid_q;
  kwmh_pkg::out_item_t  out_data_q;
  logic                 out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic [WW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  logic [PW-1:0] limit;
  logic [IW-1:0] lchild, rchild, cnt_ext;
  logic [WW-1:0] new_ent;
  logic          match;

  kwmh_ram #(.WIDTH(WW), .DEPTH(MAX_SOURCES)) u_heap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // word layout: {source, key, tag}
  always_comb begin
    logic signed [KW-1:0] ka, kb;
    ka = cmp_a[TW +: KW];
    kb = cmp_b[TW +: KW];
    if (ka != kb) begin
      cmp_lt = ka < kb;
    end else begin
      cmp_lt = cmp_a[TW+KW +: SW] < cmp_b[TW+KW +: SW];
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      limit = PW'(1);
    end else if (32'(cfg_q) > MAX_SOURCES) begin
      limit = PW'(MAX_SOURCES);
    end else begin
      limit = cfg_q;
    end
  end

  assign lchild  = {1'b0, idx_q, 1'b1};
  assign rchild  = lchild + IW'(1);
  assign cnt_ext = IW'(count_q);
  assign new_ent = {in_i.data.source_index, in_i.data.sort_key[KW-1:0], in_i.data.row_tag};
  assign match   = in_i.data.source_index == awaited_q;

  assign in_i.ready = state_q == kwmh_pkg::ST_IDLE;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    primed_cnt_d = primed_cnt_q;
    awaited_d    = awaited_q;
    primed_d     = primed_q;
    pending_d    = pending_q;
    do_pop_d     = do_pop_q;
    ent_d        = ent_q;
    min_d        = min_q;
    idx_d        = idx_q;
    midx_d       = midx_q;
    msel_d       = msel_q;
    res_src_d    = res_src_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ent_q;
    ram_raddr    = '0;
    cmp_a        = ent_q;
    cmp_b        = ram_rdata;
    out_load     = 1'b0;

    unique case (state_q)
      kwmh_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          logic take;
          logic pop;
          take = 1'b0;
          pop  = 1'b0;
          if (!primed_q) begin
            take         = 1'b1;
            primed_cnt_d = primed_cnt_q + PW'(1);
            if ({1'b0, primed_cnt_q} + 6'd1 >= {1'b0, limit}) begin
              primed_d = 1'b1;
              pop      = 1'b1;
            end
          end else if (pending_q && match) begin
            take = 1'b1;
            pop  = 1'b1;
          end
          do_pop_d = pop;
          if (take && !in_i.data.stream_ended && 32'(count_q) < MAX_SOURCES) begin
            ent_d   = new_ent;
            idx_d   = AW'(count_q);
            count_d = count_q + CW'(1);
            state_d = kwmh_pkg::ST_UP_REQ;
          end else if (pop) begin
            state_d = kwmh_pkg::ST_POP_REQ;
          end
        end
      end
      kwmh_pkg::ST_UP_REQ: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          state_d = do_pop_q ? kwmh_pkg::ST_POP_REQ : kwmh_pkg::ST_IDLE;
        end else begin
          ram_raddr = (idx_q - AW'(1)) >> 1;
          state_d   = kwmh_pkg::ST_UP_CMP;
        end
      end
      kwmh_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          idx_d     = (idx_q - AW'(1)) >> 1;
          state_d   = kwmh_pkg::ST_UP_REQ;
        end else begin
          state_d = do_pop_q ? kwmh_pkg::ST_POP_REQ : kwmh_pkg::ST_IDLE;
        end
      end
      kwmh_pkg::ST_POP_REQ: begin
        if (count_q == '0) begin
          pending_d = 1'b0;
          state_d   = kwmh_pkg::ST_IDLE;
        end else begin
          ram_raddr = '0;
          state_d   = kwmh_pkg::ST_POP_ROOT;
        end
      end
      kwmh_pkg::ST_POP_ROOT: begin
        res_src_d  = ram_rdata[TW+KW +: SW];
        res_key_d  = ram_rdata[TW +: KW];
        res_tag_d  = ram_rdata[TW-1:0];
        res_last_d = count_q == CW'(1);
        awaited_d  = ram_rdata[TW+KW +: SW];
        pending_d  = 1'b1;
        count_d    = count_q - CW'(1);
        ram_raddr  = AW'(count_q - CW'(1));
        state_d    = (count_q == CW'(1)) ? kwmh_pkg::ST_EMIT : kwmh_pkg::ST_POP_LAST;
      end
      kwmh_pkg::ST_POP_LAST: begin
        ent_d   = ram_rdata;
        idx_d   = '0;
        state_d = kwmh_pkg::ST_DN_L;
      end
      kwmh_pkg::ST_DN_L: begin
        if (lchild >= cnt_ext) begin
          ram_we  = 1'b1;
          state_d = kwmh_pkg::ST_EMIT;
        end else begin
          ram_raddr = AW'(lchild);
          state_d   = kwmh_pkg::ST_DN_LC;
        end
      end
      kwmh_pkg::ST_DN_LC: begin
        cmp_a = ram_rdata;
        cmp_b = ent_q;
        if (cmp_lt) begin
          min_d  = ram_rdata;
          midx_d = AW'(lchild);
          msel_d = 1'b1;
        end else begin
          min_d  = ent_q;
          msel_d = 1'b0;
        end
        if (rchild < cnt_ext) begin
          ram_raddr = AW'(rchild);
          state_d   = kwmh_pkg::ST_DN_RC;
        end else begin
          state_d = kwmh_pkg::ST_DN_DEC;
        end
      end
      kwmh_pkg::ST_DN_RC: begin
        cmp_a = ram_rdata;
        cmp_b = min_q;
        if (cmp_lt) begin
          min_d  = ram_rdata;
          midx_d = AW'(rchild);
          msel_d = 1'b1;
        end
        state_d = kwmh_pkg::ST_DN_DEC;
      end
      kwmh_pkg::ST_DN_DEC: begin
        ram_we = 1'b1;
        if (msel_q) begin
          ram_wdata = min_q;
          idx_d     = midx_q;
          state_d   = kwmh_pkg::ST_DN_L;
        end else begin
          state_d = kwmh_pkg::ST_EMIT;
        end
      end
      kwmh_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = kwmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwmh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kwmh_pkg::ST_IDLE;
      cfg_q        <= kwmh_pkg::CFG_RESET;
      count_q      <= '0;
      primed_cnt_q <= '0;
      awaited_q    <= '0;
      primed_q     <= 1'b0;
      pending_q    <= 1'b0;
      do_pop_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      primed_cnt_q <= primed_cnt_d;
      awaited_q    <= awaited_d;
      primed_q     <= primed_d;
      pending_q    <= pending_d;
      do_pop_q     <= do_pop_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [KW-1:0] rkey;
    rkey       = res_key_q;
    ent_q      <= ent_d;
    min_q      <= min_d;
    idx_q      <= idx_d;
    midx_q     <= midx_d;
    msel_q     <= msel_d;
    res_src_q  <= res_src_d;
    res_key_q  <= res_key_d;
    res_tag_q  <= res_tag_d;
    res_last_q <= res_last_d;
    if (out_load) begin
      out_data_q.out_source <= res_src_q;
      out_data_q.out_key    <= kwmh_pkg::KEY_W'(rkey);
      out_data_q.out_tag    <= res_tag_q;
      out_data_q.last       <= res_last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
